FILE: src/bcpe_pkg.sv
// shared types, constants and helper functions of the bezier point evaluator
`default_nettype none
package bcpe_pkg;

	// default curve degree, the number of control point registers and the lane count
	localparam int DEGREE     = 6;
	localparam int NUM_POINTS = 7;
	localparam int LANES      = 8;

	// field and register widths
	localparam int T_W     = 16;
	localparam int COORD_W = 16;
	localparam int POINT_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int WGT_W   = 21;
	localparam int TERM_W  = WGT_W + 1 + COORD_W;
	localparam int ACC_W   = TERM_W + 3;

	// Q1.15 constants
	localparam logic [T_W-1:0] ONE_Q15  = 16'h8000;
	localparam logic [32:0]    HALF_Q15 = 33'd16384;

	typedef logic [T_W-1:0]            pow_t;
	typedef logic [WGT_W-1:0]          weight_t;
	typedef logic [POINT_W-1:0]        point_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	// degree limited to the supported span
	function automatic int eff_degree(int d);
		int r;
		r = d;
		if (r < 1) r = 1;
		if (r > 7) r = 7;
		return r;
	endfunction

	// binomial coefficient through pascal's triangle
	function automatic int binom(int n, int k);
		int c [8];
		for (int j = 0; j < 8; j++) c[j] = (j == 0) ? 1 : 0;
		for (int r = 1; r <= n; r++) begin
			for (int j = 7; j >= 1; j--) begin
				if (j <= r) c[j] = c[j] + c[j-1];
			end
		end
		return c[k];
	endfunction

	// cycles from an accepted item to its result
	function automatic int latency(int d);
		return eff_degree(d) + 7;
	endfunction

	// q1.15 product, rounded half up
	function automatic pow_t mul_rnd(pow_t a, pow_t b);
		logic [31:0] m;
		logic [32:0] p;
		m = a * b;
		p = {1'b0, m} + HALF_Q15;
		return p[30:15];
	endfunction

	// q25 sum back to q5.10 with rounding and saturation
	function automatic coord_t round_sat(acc_t acc);
		logic signed [ACC_W:0] b;
		logic signed [ACC_W-15:0] q;
		b = (ACC_W+1)'(acc) + (ACC_W+1)'(signed'(HALF_Q15));
		q = b[ACC_W:15];
		if (q > (ACC_W-14)'(32767)) return 16'sh7fff;
		else if (q < -(ACC_W-14)'(32768)) return 16'sh8000;
		else return q[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: src/bcpe_ifs.sv
// handshake channel interfaces of the bezier point evaluator
`default_nettype none
interface bcpe_in_if;
	logic                   valid;
	logic                   ready;
	logic [bcpe_pkg::T_W-1:0] t_param;
	modport source (output valid, output t_param, input ready);
	modport sink   (input valid, input t_param, output ready);
endinterface

interface bcpe_out_if;
	logic                valid;
	logic                ready;
	bcpe_pkg::coord_t    x_out;
	bcpe_pkg::coord_t    y_out;
	modport source (output valid, output x_out, output y_out, input ready);
	modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

interface bcpe_cfg_if;
	logic                valid;
	logic                ready;
	bcpe_pkg::cfg_idx_t  index;
	bcpe_pkg::point_t    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/bcpe_powers.sv
// power chain of t and 1-t, one q1.15 multiply per stage after the first
`default_nettype none
module bcpe_powers #(
	parameter int DEGREE = bcpe_pkg::DEGREE
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire bcpe_pkg::pow_t  t_param,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bcpe_pkg::pow_t       tp [0:bcpe_pkg::eff_degree(DEGREE)],
	output bcpe_pkg::pow_t       up [0:bcpe_pkg::eff_degree(DEGREE)]
);
	localparam int D = bcpe_pkg::eff_degree(DEGREE);

	logic           vld_s [1:D];
	logic           rdy   [1:D+1];
	bcpe_pkg::pow_t tp_s  [1:D][0:D];
	bcpe_pkg::pow_t up_s  [1:D][0:D];
	bcpe_pkg::pow_t t_c;
	bcpe_pkg::pow_t u_c;

	// stage ready: empty or downstream moving
	assign rdy[D+1] = out_ready;
	for (genvar j = 1; j <= D; j++) begin : g_rdy
		assign rdy[j] = !vld_s[j] || rdy[j+1];
	end
	assign in_ready = rdy[1];

	// t above one acts as one
	assign t_c = (t_param > bcpe_pkg::ONE_Q15) ? bcpe_pkg::ONE_Q15 : t_param;
	assign u_c = bcpe_pkg::ONE_Q15 - t_c;

	// first stage: clamped t and 1-t as first powers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (rdy[1]) begin
			vld_s[1] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1] && in_valid) begin
			for (int k = 0; k <= D; k++) begin
				tp_s[1][k] <= (k == 0) ? bcpe_pkg::ONE_Q15 : (k == 1) ? t_c : '0;
				up_s[1][k] <= (k == 0) ? bcpe_pkg::ONE_Q15 : (k == 1) ? u_c : '0;
			end
		end
	end

	// later stages: next power from the previous one
	for (genvar j = 2; j <= D; j++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && vld_s[j-1]) begin
				for (int k = 0; k <= D; k++) begin
					if (k == j) begin
						tp_s[j][k] <= bcpe_pkg::mul_rnd(tp_s[j-1][j-1], tp_s[j-1][1]);
						up_s[j][k] <= bcpe_pkg::mul_rnd(up_s[j-1][j-1], up_s[j-1][1]);
					end else begin
						tp_s[j][k] <= tp_s[j-1][k];
						up_s[j][k] <= up_s[j-1][k];
					end
				end
			end
		end
	end

	assign out_valid = vld_s[D];
	assign tp = tp_s[D];
	assign up = up_s[D];

endmodule
`default_nettype wire

FILE: src/bcpe_weights.sv
// bernstein weights: cross product of powers, then binomial scaling
`default_nettype none
module bcpe_weights #(
	parameter int DEGREE = bcpe_pkg::DEGREE
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire bcpe_pkg::pow_t  tp [0:bcpe_pkg::eff_degree(DEGREE)],
	input  wire bcpe_pkg::pow_t  up [0:bcpe_pkg::eff_degree(DEGREE)],
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bcpe_pkg::weight_t    w [bcpe_pkg::LANES]
);
	localparam int D = bcpe_pkg::eff_degree(DEGREE);

	logic              vld_s1;
	logic              vld_s2;
	logic              rdy1;
	logic              rdy2;
	bcpe_pkg::pow_t    m_s1 [0:D];
	bcpe_pkg::weight_t w_s2 [0:D];

	assign rdy2     = !vld_s2 || out_ready;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
		end
	end

	// t^i times (1-t)^(n-i), rounded
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int i = 0; i <= D; i++) begin
				m_s1[i] <= bcpe_pkg::mul_rnd(tp[i], up[D-i]);
			end
		end
	end

	// binomial scaling by a constant per lane
	for (genvar i = 0; i <= D; i++) begin : g_scale
		localparam logic [5:0] COEF = 6'(bcpe_pkg::binom(D, i));
		always_ff @(posedge clk) begin
			if (rdy2 && vld_s1) begin
				w_s2[i] <= bcpe_pkg::WGT_W'(m_s1[i]) * bcpe_pkg::WGT_W'(COEF);
			end
		end
	end

	// lanes past the degree or past the last point carry zero
	for (genvar l = 0; l < bcpe_pkg::LANES; l++) begin : g_lane
		if (l <= D && l < bcpe_pkg::NUM_POINTS) begin : g_used
			assign w[l] = w_s2[l];
		end else begin : g_zero
			assign w[l] = '0;
		end
	end

	assign out_valid = vld_s2;

endmodule
`default_nettype wire

FILE: src/bcpe_accum.sv
// weighted sum of control points: products, adder tree, rounding
`default_nettype none
module bcpe_accum (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bcpe_pkg::weight_t w [bcpe_pkg::LANES],
	input  wire bcpe_pkg::point_t  points [bcpe_pkg::NUM_POINTS],
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bcpe_pkg::coord_t       x_out,
	output bcpe_pkg::coord_t       y_out
);
	localparam int NS = 5;

	logic             vld_s [1:NS];
	logic             vin   [1:NS];
	logic             rdy   [1:NS+1];
	logic             en    [1:NS];
	bcpe_pkg::term_t  tx_s1 [bcpe_pkg::LANES];
	bcpe_pkg::term_t  ty_s1 [bcpe_pkg::LANES];
	logic signed [bcpe_pkg::TERM_W:0]   sx_s2 [4];
	logic signed [bcpe_pkg::TERM_W:0]   sy_s2 [4];
	logic signed [bcpe_pkg::TERM_W+1:0] sx_s3 [2];
	logic signed [bcpe_pkg::TERM_W+1:0] sy_s3 [2];
	bcpe_pkg::acc_t   sx_s4;
	bcpe_pkg::acc_t   sy_s4;
	bcpe_pkg::coord_t x_s5;
	bcpe_pkg::coord_t y_s5;

	// stage handshake
	assign rdy[NS+1] = out_ready;
	assign vin[1]    = in_valid;
	for (genvar j = 1; j <= NS; j++) begin : g_ctl
		assign rdy[j] = !vld_s[j] || rdy[j+1];
		assign en[j]  = rdy[j] && vin[j];
		if (j > 1) begin : g_vin
			assign vin[j] = vld_s[j-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_s[j] <= vin[j];
			end
		end
	end
	assign in_ready = rdy[1];

	// weight times coordinate per lane
	for (genvar l = 0; l < bcpe_pkg::LANES; l++) begin : g_term
		if (l < bcpe_pkg::NUM_POINTS) begin : g_used
			logic signed [bcpe_pkg::WGT_W:0] ws;
			bcpe_pkg::coord_t                px;
			bcpe_pkg::coord_t                py;
			assign ws = signed'({1'b0, w[l]});
			assign px = signed'(points[l][31:16]);
			assign py = signed'(points[l][15:0]);
			always_ff @(posedge clk) begin
				if (en[1]) begin
					tx_s1[l] <= ws * px;
					ty_s1[l] <= ws * py;
				end
			end
		end else begin : g_zero
			always_ff @(posedge clk) begin
				if (en[1]) begin
					tx_s1[l] <= '0;
					ty_s1[l] <= '0;
				end
			end
		end
	end

	// adder tree, one level per stage, then rounding
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < 4; k++) begin
				sx_s2[k] <= (bcpe_pkg::TERM_W+1)'(tx_s1[2*k]) + (bcpe_pkg::TERM_W+1)'(tx_s1[2*k+1]);
				sy_s2[k] <= (bcpe_pkg::TERM_W+1)'(ty_s1[2*k]) + (bcpe_pkg::TERM_W+1)'(ty_s1[2*k+1]);
			end
		end
		if (en[3]) begin
			for (int k = 0; k < 2; k++) begin
				sx_s3[k] <= (bcpe_pkg::TERM_W+2)'(sx_s2[2*k]) + (bcpe_pkg::TERM_W+2)'(sx_s2[2*k+1]);
				sy_s3[k] <= (bcpe_pkg::TERM_W+2)'(sy_s2[2*k]) + (bcpe_pkg::TERM_W+2)'(sy_s2[2*k+1]);
			end
		end
		if (en[4]) begin
			sx_s4 <= bcpe_pkg::ACC_W'(sx_s3[0]) + bcpe_pkg::ACC_W'(sx_s3[1]);
			sy_s4 <= bcpe_pkg::ACC_W'(sy_s3[0]) + bcpe_pkg::ACC_W'(sy_s3[1]);
		end
		if (en[5]) begin
			x_s5 <= bcpe_pkg::round_sat(sx_s4);
			y_s5 <= bcpe_pkg::round_sat(sy_s4);
		end
	end

	assign out_valid = vld_s[NS];
	assign x_out     = x_s5;
	assign y_out     = y_s5;

endmodule
`default_nettype wire

FILE: src/bezier_curve_point_evaluator.sv
// top level of the degree-n bezier curve point evaluator
//
//  channel  dir  payload                      item
//  t_in     in   t_param (u q1.15)            one curve parameter
//  pt_out   out  x_out, y_out (s q5.10)       one curve point
//  cfg      in   index (3b), data (32b)       one control point write
//
// one item per cycle while pt_out is ready; the pipeline is the chain of
// q1.15 power stages plus weight, product, tree and rounding stages. each
// stage has its own valid bit and moves when it is empty or the next one
// moves, so bubbles close up under a stall and nothing is dropped.
// reset clears all valid bits and the control points; cfg is always ready.
`default_nettype none
module bezier_curve_point_evaluator #(
	parameter int DEGREE = bcpe_pkg::DEGREE
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bcpe_in_if.sink    t_in,
	bcpe_out_if.source pt_out,
	bcpe_cfg_if.sink   cfg
);
	localparam int D = bcpe_pkg::eff_degree(DEGREE);

	bcpe_pkg::point_t  point_q [bcpe_pkg::NUM_POINTS];
	bcpe_pkg::pow_t    tp [0:D];
	bcpe_pkg::pow_t    up [0:D];
	bcpe_pkg::weight_t w  [bcpe_pkg::LANES];
	logic              pw_valid;
	logic              pw_ready;
	logic              wt_valid;
	logic              wt_ready;

	// control point registers; writes past the last point are dropped
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bcpe_pkg::NUM_POINTS; i++) point_q[i] <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (32'(cfg.index) < bcpe_pkg::NUM_POINTS) point_q[cfg.index] <= cfg.data;
		end
	end

	// powers of t and 1-t
	bcpe_powers #(.DEGREE(DEGREE)) u_powers (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t_in.valid),
		.in_ready  (t_in.ready),
		.t_param   (t_in.t_param),
		.out_valid (pw_valid),
		.out_ready (pw_ready),
		.tp        (tp),
		.up        (up)
	);

	// bernstein weights
	bcpe_weights #(.DEGREE(DEGREE)) u_weights (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pw_valid),
		.in_ready  (pw_ready),
		.tp        (tp),
		.up        (up),
		.out_valid (wt_valid),
		.out_ready (wt_ready),
		.w         (w)
	);

	// weighted sum, rounding and output register
	bcpe_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wt_valid),
		.in_ready  (wt_ready),
		.w         (w),
		.points    (point_q),
		.out_valid (pt_out.valid),
		.out_ready (pt_out.ready),
		.x_out     (pt_out.x_out),
		.y_out     (pt_out.y_out)
	);

endmodule
`default_nettype wire

FILE: src/bcpe_checker.sv
// port-level checks of the bezier point evaluator and their binding
`default_nettype none
module bcpe_checker #(
	parameter int DEGREE = bcpe_pkg::DEGREE
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire bcpe_pkg::coord_t x_out,
	input wire bcpe_pkg::coord_t y_out
);
	localparam int DEPTH = bcpe_pkg::latency(DEGREE);
	localparam int CNT_W = $clog2(DEPTH + 2);

	logic [CNT_W-1:0] inflight_q;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_valid && in_ready)
				- CNT_W'(out_valid && out_ready);
		end
	end

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out))
		else $error("stalled result changed or vanished");

	// no result without an item in flight
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> !out_valid)
		else $error("result with no item in flight");

	// the pipeline never holds more than its stage count
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(DEPTH))
		else $error("more items in flight than stages");

	// an empty pipeline takes an item
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> in_ready)
		else $error("empty pipeline not ready");

endmodule

bind bezier_curve_point_evaluator bcpe_checker #(.DEGREE(DEGREE)) u_bcpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (t_in.valid),
	.in_ready  (t_in.ready),
	.out_valid (pt_out.valid),
	.out_ready (pt_out.ready),
	.x_out     (pt_out.x_out),
	.y_out     (pt_out.y_out)
);
`default_nettype wire
